// ----- rtl/atlas_tile_slot_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the atlas tile slot allocator
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ATLAS_TILE_SLOT_ALLOCATOR_ASSERT_SVH
`define ATLAS_TILE_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define ATSA_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("atsa: assertion failed");
// when pre holds, post holds at the next edge
`define ATSA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("atsa: assertion failed");
`else
`define ATSA_ASSERT(label, cond)
`define ATSA_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- rtl/atsa_pkg.sv -----
// ----------------------------------------------------------------------------
// atsa_pkg
// Shared types, codes and constants of the atlas tile slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package atsa_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_SLOTS = 1024;

  // occupancy bitmap word
  localparam int WORD_BITS = 32;
  localparam int WORD_LOG2 = 5;

  // commands
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TILE_W    = 2'd0;
  localparam logic [1:0] REG_TILE_H    = 2'd1;
  localparam logic [1:0] REG_SLOT_LIMIT = 2'd2;

  // width of a slot position that can also hold the slot count
  function automatic int pos_width(input int max_slots);
    int rows;
    rows = (max_slots + WORD_BITS - 1) / WORD_BITS;
    return $clog2(rows * WORD_BITS) + 1;
  endfunction

  typedef struct packed {
    logic       command;
    logic [9:0] slot_index;
  } atsa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  given_slot;
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic        layer_full;
    logic [2:0]  grid_log2;
    logic [4:0]  texture_log2;
  } atsa_out_t;

  // classified command handed from front to back
  typedef struct packed {
    logic       is_add;
    logic [9:0] slot_index;
  } atsa_cmd_t;

  typedef struct packed {
    logic [3:0]  tile_width_log2;
    logic [3:0]  tile_height_log2;
    logic [10:0] slot_limit;
  } atsa_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/atlas_tile_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// atlas_tile_slot_allocator
// Slot allocator for one atlas layer of equal power-of-two tiles.
// ----------------------------------------------------------------------------
// Commands are taken into a two-entry queue and run one at a time; each gives
// one result beat. A full add, or a remove whose index is at or above the
// high-water mark, goes straight to the result state. Other removes read the
// bitmap word and clear the bit if it is set. An add that fills a hole marks
// its word, then searches for the next free slot up to the high-water mark,
// reading one further 32-slot bitmap word per cycle; an add at the high-water
// mark grows it and skips the search. Adds then compute the pixel position.
// A result beat that is not taken holds the back part. The bitmap needs no
// clearing pass: words above the high-water mark read as empty. Configuration
// must be written only while the block is idle; the block does not enforce it.
`default_nettype none

module atlas_tile_slot_allocator #(
  parameter int MAX_SLOTS = atsa_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire atsa_pkg::atsa_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output atsa_pkg::atsa_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [10:0]         cfg_data
);

  `include "atlas_tile_slot_allocator_assert.svh"

  localparam int PW = atsa_pkg::pos_width(MAX_SLOTS);

  atsa_pkg::atsa_cfg_t cfg_r;
  logic                q_valid;
  atsa_pkg::atsa_cmd_t q_cmd;
  logic                q_pop;
  logic [PW-1:0]       first_free;
  logic [PW-1:0]       high_water;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_width_log2  <= 4'd0;
      cfg_r.tile_height_log2 <= 4'd0;
      cfg_r.slot_limit       <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        atsa_pkg::REG_TILE_W:     cfg_r.tile_width_log2  <= cfg_data[3:0];
        atsa_pkg::REG_TILE_H:     cfg_r.tile_height_log2 <= cfg_data[3:0];
        atsa_pkg::REG_SLOT_LIMIT: cfg_r.slot_limit       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  atsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  atsa_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .PW        (PW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .first_free (first_free),
    .high_water (high_water)
  );

  // first free slot never passes the high-water mark
  `ATSA_ASSERT(a_ff_le_hw, first_free <= high_water)
  // the high-water mark only grows
  `ATSA_ASSERT_NEXT(a_hw_grows, 1'b1, high_water >= $past(high_water))
  // a full add always reports the layer as full
  `ATSA_ASSERT(a_full_flag, !(out_valid && out_data.status == atsa_pkg::ST_FULL) || out_data.layer_full)

endmodule

`default_nettype wire

// ----- rtl/atsa_front.sv -----
// ----------------------------------------------------------------------------
// atsa_front
// Accepts command beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module atsa_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire atsa_pkg::atsa_in_t in_data,
  output logic                    q_valid,
  output atsa_pkg::atsa_cmd_t     q_cmd,
  input  wire logic               q_pop
);

  atsa_pkg::atsa_cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // classify on entry
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r].is_add     <= (in_data.command == atsa_pkg::CMD_ADD);
      entry_r[wr_ptr_r].slot_index <= in_data.slot_index;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/atsa_back.sv -----
// ----------------------------------------------------------------------------
// atsa_back
// Executes add and remove commands against the occupancy bitmap and builds
// the result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atsa_back #(
  parameter int MAX_SLOTS = atsa_pkg::DEF_MAX_SLOTS,
  parameter int PW        = atsa_pkg::pos_width(atsa_pkg::DEF_MAX_SLOTS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire atsa_pkg::atsa_cfg_t cfg,
  input  wire logic                q_valid,
  input  wire atsa_pkg::atsa_cmd_t q_cmd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output atsa_pkg::atsa_out_t      out_data,
  output logic [PW-1:0]            first_free,
  output logic [PW-1:0]            high_water
);

  localparam int WB   = atsa_pkg::WORD_LOG2;
  localparam int WBIT = atsa_pkg::WORD_BITS;
  localparam int ROWS = (MAX_SLOTS + WBIT - 1) / WBIT;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW   = (PW > 11) ? PW : 11;
  localparam int CLW  = $clog2(PW + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_ADD = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RD_REM = 3'd3;
  localparam logic [2:0] S_PIX    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  // occupancy bitmap, one row per word
  logic [WBIT-1:0] mem [ROWS];
  logic [WBIT-1:0] rd_data_r;
  logic            rd_en;
  logic [RW-1:0]   rd_row;
  logic            wr_en;
  logic [RW-1:0]   wr_row;
  logic [WBIT-1:0] wr_data;

  logic [2:0]      state_r, state_nxt;
  logic [PW-1:0]   ff_r, ff_nxt;
  logic [PW-1:0]   hw_r, hw_nxt;
  logic [PW-1:0]   slot_r, slot_nxt;
  logic [PW-1:0]   scan_r, scan_nxt;
  logic            rowv_r, rowv_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [9:0]      given_r, given_nxt;
  logic [13:0]     px_r, px_nxt;
  logic [13:0]     py_r, py_nxt;
  logic            out_valid_r, out_valid_nxt;
  atsa_pkg::atsa_out_t out_r, out_nxt;

  // shared combinational terms
  logic [3:0]      tile_d;
  logic [3:0]      tile_big;
  logic [LW-1:0]   lim;
  logic [WBIT-1:0] word;
  logic [WBIT-1:0] bit_mask;
  logic [WBIT-1:0] low_mask;
  logic [WB:0]     fz;
  logic [PW-1:0]   cur_pos;
  logic [PW-1:0]   cand;
  logic [PW-1:0]   next_row;
  logic [PW-1:0]   hm1;
  logic [PW-1:0]   gv;
  logic [CLW-1:0]  bitlen;
  logic [3:0]      grid_full;
  logic [PW-1:0]   sv;
  logic [PW-1:0]   sv1;
  logic [27:0]     svx;
  logic [27:0]     sv1x;
  logic [13:0]     xe;
  logic [13:0]     ye;
  logic [15:0]     yy;
  logic [13:0]     xs;
  logic [13:0]     ys;

  function automatic logic [RW-1:0] row_of(input logic [PW-1:0] p);
    return RW'(p >> WB);
  endfunction

  // lowest clear bit of a word: {found, position}
  function automatic logic [WB:0] first_zero(input logic [WBIT-1:0] w);
    logic [WB:0] r;
    r = '0;
    for (int i = WBIT - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = {1'b1, WB'(i)};
      end
    end
    return r;
  endfunction

  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign first_free = ff_r;
  assign high_water = hw_r;

  // tile shape terms and effective limit
  always_comb begin
    if (cfg.tile_width_log2 > cfg.tile_height_log2) begin
      tile_d   = cfg.tile_width_log2 - cfg.tile_height_log2;
      tile_big = cfg.tile_width_log2;
    end else begin
      tile_d   = cfg.tile_height_log2 - cfg.tile_width_log2;
      tile_big = cfg.tile_height_log2;
    end
    if (LW'(cfg.slot_limit) < LW'(MAX_SLOTS)) begin
      lim = LW'(cfg.slot_limit);
    end else begin
      lim = LW'(MAX_SLOTS);
    end
  end

  // Morton placement of the current slot, short side on the low bits
  always_comb begin
    sv   = slot_r >> tile_d;
    sv1  = slot_r >> ({1'b0, tile_d} + 5'd1);
    svx  = 28'(sv);
    sv1x = 28'(sv1);
    for (int i = 0; i < 14; i++) begin
      xe[i] = svx[2*i];
      ye[i] = sv1x[2*i];
    end
    yy = (16'(ye) << tile_d) | (16'(slot_r) & ~(16'hFFFF << tile_d));
    if (cfg.tile_width_log2 < cfg.tile_height_log2) begin
      xs = yy[13:0];
      ys = xe;
    end else begin
      xs = xe;
      ys = yy[13:0];
    end
  end

  // grid size needed for the high-water count
  always_comb begin
    hm1    = hw_r - PW'(1);
    gv     = hm1 >> tile_d;
    bitlen = '0;
    for (int i = 0; i < PW; i++) begin
      if (gv[i]) begin
        bitlen = CLW'(i + 1);
      end
    end
    if (hw_r == '0) begin
      grid_full = 4'd0;
    end else begin
      grid_full = 4'((5'(bitlen) + 5'd1) >> 1);
    end
  end

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    ff_nxt        = ff_r;
    hw_nxt        = hw_r;
    slot_nxt      = slot_r;
    scan_nxt      = scan_r;
    rowv_nxt      = rowv_r;
    status_nxt    = status_r;
    given_nxt     = given_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_row        = '0;
    wr_en         = 1'b0;
    wr_row        = '0;
    wr_data       = '0;
    word          = rowv_r ? rd_data_r : '0;
    cur_pos       = (state_r == S_SCAN) ? scan_r : slot_r;
    bit_mask      = WBIT'(1) << cur_pos[WB-1:0];
    low_mask      = WBIT'(((WBIT+1)'(2) << cur_pos[WB-1:0]) - (WBIT+1)'(1));
    fz            = '0;
    cand          = {cur_pos[PW-1:WB], fz[WB-1:0]};
    next_row      = {cur_pos[PW-1:WB] + 1'b1, WB'(0)};

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          px_nxt = '0;
          py_nxt = '0;
          if (q_cmd.is_add) begin
            if (LW'(ff_r) >= lim) begin
              status_nxt = atsa_pkg::ST_FULL;
              given_nxt  = '0;
              state_nxt  = S_FIN;
            end else begin
              status_nxt = atsa_pkg::ST_OK;
              slot_nxt   = ff_r;
              given_nxt  = 10'(ff_r);
              rd_en      = 1'b1;
              rd_row     = row_of(ff_r);
              rowv_nxt   = ({ff_r[PW-1:WB], WB'(0)} < hw_r);
              state_nxt  = S_RD_ADD;
            end
          end else begin
            given_nxt = q_cmd.slot_index;
            if (LW'(q_cmd.slot_index) >= LW'(hw_r) ||
                LW'(q_cmd.slot_index) >= LW'(MAX_SLOTS)) begin
              status_nxt = atsa_pkg::ST_BAD;
              state_nxt  = S_FIN;
            end else begin
              status_nxt = atsa_pkg::ST_OK;
              slot_nxt   = PW'(q_cmd.slot_index);
              rd_en      = 1'b1;
              rd_row     = row_of(PW'(q_cmd.slot_index));
              rowv_nxt   = 1'b1;
              state_nxt  = S_RD_REM;
            end
          end
        end
      end

      S_RD_ADD, S_SCAN: begin
        if (state_r == S_RD_ADD) begin
          // mark the slot, then look for a gap above it in the same word
          wr_en   = 1'b1;
          wr_row  = row_of(slot_r);
          wr_data = word | bit_mask;
          fz      = first_zero(word | bit_mask | low_mask);
        end else begin
          fz      = first_zero(word);
        end
        cand = {cur_pos[PW-1:WB], fz[WB-1:0]};
        if (state_r == S_RD_ADD && slot_r >= hw_r) begin
          // slot at the high-water mark: grow
          hw_nxt    = slot_r + PW'(1);
          ff_nxt    = slot_r + PW'(1);
          state_nxt = S_PIX;
        end else if (fz[WB]) begin
          ff_nxt    = (cand < hw_r) ? cand : hw_r;
          state_nxt = S_PIX;
        end else if (next_row >= hw_r) begin
          ff_nxt    = hw_r;
          state_nxt = S_PIX;
        end else begin
          scan_nxt  = next_row;
          rd_en     = 1'b1;
          rd_row    = row_of(next_row);
          rowv_nxt  = 1'b1;
          state_nxt = S_SCAN;
        end
      end

      S_RD_REM: begin
        if (!word[slot_r[WB-1:0]]) begin
          status_nxt = atsa_pkg::ST_BAD;
        end else begin
          wr_en   = 1'b1;
          wr_row  = row_of(slot_r);
          wr_data = word & ~bit_mask;
          if (slot_r < ff_r) begin
            ff_nxt = slot_r;
          end
        end
        state_nxt = S_FIN;
      end

      S_PIX: begin
        px_nxt    = xs << cfg.tile_width_log2;
        py_nxt    = ys << cfg.tile_height_log2;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = status_r;
          out_nxt.given_slot   = given_r;
          out_nxt.pixel_x      = px_r;
          out_nxt.pixel_y      = py_r;
          out_nxt.layer_full   = (LW'(ff_r) >= lim);
          out_nxt.grid_log2    = grid_full[2:0];
          out_nxt.texture_log2 = 5'(5'(tile_big) + 5'(grid_full));
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // bitmap port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ff_r        <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ff_r        <= ff_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    scan_r   <= scan_nxt;
    rowv_r   <= rowv_nxt;
    status_r <= status_nxt;
    given_r  <= given_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- dv/atlas_tile_slot_allocator_test.sv -----
// ----------------------------------------------------------------------------
// atlas_tile_slot_allocator_test
// Self-checking bench for the tile slot allocator. The bench drives add and
// remove commands over a valid/ready channel and predicts every result beat
// from its own model of the occupancy map and the pointers. Each result is
// compared as a whole beat with the oldest prediction, over several tile
// shapes and slot limits.
// ----------------------------------------------------------------------------
`default_nettype none

module atlas_tile_slot_allocator_test;

  localparam int SLOTS     = 1024;
  localparam int WDOG_MAX  = 20000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  atsa_pkg::atsa_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  atsa_pkg::atsa_out_t out_data;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [10:0]         cfg_data;

  atlas_tile_slot_allocator #(.MAX_SLOTS(SLOTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [3:0]  mdl_tw;
  logic [3:0]  mdl_th;
  logic [10:0] mdl_limit;
  bit          mdl_occ [SLOTS];
  int unsigned mdl_first;
  int unsigned mdl_hw;

  atsa_pkg::atsa_out_t expected_q [$];
  int          mismatches;
  int          beats_in;
  int          beats_out;
  int          idle_cycles;
  bit          rx_hold;     // receiver held off for a long stretch
  bit          rx_random;   // receiver draws random stalls

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned even_bits(input int unsigned v);
    int unsigned r;
    r = 0;
    for (int i = 0; i < 16; i++) r |= ((v >> (2 * i)) & 1) << i;
    return r;
  endfunction

  function automatic int unsigned clog2_u(input int unsigned v);
    int unsigned n;
    n = 0;
    while (n < 32 && (64'd1 << n) < v) n++;
    return n;
  endfunction

  // one allocator step: updates the model and returns the predicted beat
  function automatic atsa_pkg::atsa_out_t alloc_predict(input atsa_pkg::atsa_in_t cmd);
    atsa_pkg::atsa_out_t r;
    int unsigned lim, d, slot, x, y, t, s, grid, big;
    r = '0;
    lim = (mdl_limit < SLOTS) ? mdl_limit : SLOTS;
    d = (mdl_tw > mdl_th) ? mdl_tw - mdl_th : mdl_th - mdl_tw;
    if (cmd.command == atsa_pkg::CMD_ADD) begin
      if (mdl_first >= lim) begin
        r.status = atsa_pkg::ST_FULL;
      end else begin
        slot = mdl_first;
        x = even_bits(slot >> d);
        y = even_bits(slot >> (d + 1));
        y = (y << d) | (slot & ((1 << d) - 1));
        if (mdl_tw < mdl_th) begin
          t = x; x = y; y = t;
        end
        r.status = atsa_pkg::ST_OK;
        r.pixel_x = 14'((64'(x) << mdl_tw) & 64'h3fff);
        r.pixel_y = 14'((64'(y) << mdl_th) & 64'h3fff);
        r.given_slot = 10'(slot);
        mdl_occ[slot] = 1'b1;
        if (slot < mdl_hw) begin
          s = slot + 1;
          while (s < mdl_hw && mdl_occ[s]) s++;
          mdl_first = s;
        end else begin
          mdl_hw = slot + 1;
          mdl_first = slot + 1;
        end
      end
    end else begin
      r.given_slot = cmd.slot_index;
      if (cmd.slot_index >= mdl_hw || !mdl_occ[cmd.slot_index]) begin
        r.status = atsa_pkg::ST_BAD;
      end else begin
        mdl_occ[cmd.slot_index] = 1'b0;
        if (cmd.slot_index < mdl_first) mdl_first = cmd.slot_index;
      end
    end
    if (mdl_hw == 0) grid = 0;
    else grid = (clog2_u(((mdl_hw - 1) >> d) + 1) + 1) >> 1;
    big = (mdl_tw > mdl_th) ? mdl_tw : mdl_th;
    r.layer_full = (mdl_first >= lim);
    r.grid_log2 = 3'(grid);
    r.texture_log2 = 5'(big + grid);
    return r;
  endfunction

  // send one beat after a random gap; valid stays up until the next gap
  task automatic send_cmd(input logic c, input logic [9:0] idx, input bit gap = 1'b1);
    atsa_pkg::atsa_in_t it;
    int                 wait_n;
    it.command = c;
    it.slot_index = idx;
    wait_n = gap ? $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16) : 0;
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q = {expected_q, alloc_predict(it)};
    beats_in++;
  endtask

  // wait until every predicted beat has come, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 11'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      atsa_pkg::REG_TILE_W:     mdl_tw    = 4'(val);
      atsa_pkg::REG_TILE_H:     mdl_th    = 4'(val);
      atsa_pkg::REG_SLOT_LIMIT: mdl_limit = 11'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_shape(input int unsigned w, input int unsigned h,
                           input int unsigned lim);
    drain();
    write_reg(atsa_pkg::REG_TILE_W, w);
    write_reg(atsa_pkg::REG_TILE_H, h);
    write_reg(atsa_pkg::REG_SLOT_LIMIT, lim);
  endtask

  // result checker
  always @(posedge clk) begin
    atsa_pkg::atsa_out_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        e = expected_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n_wait;
    out_ready = 1'b0;
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else if (!rx_random) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n_wait = $urandom_range(0, 16);
        if (n_wait > 0) begin
          out_ready <= 1'b0;
          repeat (n_wait) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_directed;
    send_cmd(atsa_pkg::CMD_REMOVE, 10'd0);    // remove on an empty layer
    send_cmd(atsa_pkg::CMD_ADD, 10'h3ff);
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    send_cmd(atsa_pkg::CMD_REMOVE, 10'd1);    // good remove, opens a hole
    send_cmd(atsa_pkg::CMD_REMOVE, 10'd1);    // remove of a free slot
    send_cmd(atsa_pkg::CMD_REMOVE, 10'h3ff);  // above high water
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);       // fills the hole
    set_shape(15, 0, 4);                      // wide tiles, large size masked
    repeat (3) send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);       // layer full
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    set_shape(0, 15, 2);                      // limit lowered below first free
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    send_cmd(atsa_pkg::CMD_REMOVE, 10'd0);
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    set_shape(3, 3, 0);                       // zero limit
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    set_shape(2, 5, 11'h7ff);                 // limit above slot count
    send_cmd(atsa_pkg::CMD_ADD, 10'd0);
    send_cmd(atsa_pkg::CMD_REMOVE, 10'd3);
  endtask

  // mostly adds and removes of live slots, some noise
  task automatic run_random(input int n, input int add_pct);
    logic [9:0] idx;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        send_cmd(atsa_pkg::CMD_ADD, 10'($urandom));
      end else begin
        if ($urandom_range(0, 4) == 0 || mdl_hw == 0) idx = 10'($urandom);
        else idx = 10'($urandom_range(0, mdl_hw - 1));
        send_cmd(atsa_pkg::CMD_REMOVE, idx);
      end
    end
  endtask

  task automatic test_random;
    set_shape(1, 1, 64);
    run_random(150, 60);
    set_shape(4, 1, 200);
    run_random(150, 55);
    set_shape(0, 7, 1024);
    run_random(200, 65);
    set_shape($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 2047));
    run_random(150, 50);
    set_shape(14, 14, 1);
    run_random(40, 50);
  endtask

  // hold the receiver so the input queue backs up, then release
  task automatic test_backpressure;
    int n;
    set_shape(2, 3, 512);
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        n = 0;
        while (rx_hold && n < 20) begin
          send_cmd(1'($urandom_range(0, 1)), 10'($urandom_range(0, 15)), 1'b0);
          n++;
        end
      end
    join
    drain();                               // sender pauses until all came back
    run_random(240, 60);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_index = atsa_pkg::REG_TILE_W; cfg_data = '0;
    rx_hold = 1'b0; rx_random = 1'b0;
    mismatches = 0; beats_in = 0; beats_out = 0; idle_cycles = 0;
    mdl_tw = 0; mdl_th = 0; mdl_limit = 11'd1024;
    mdl_first = 0; mdl_hw = 0;
    foreach (mdl_occ[i]) mdl_occ[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    rx_random = 1'b1;
    test_random();
    test_backpressure();
    drain();
    $display("covered %0d commands and %0d results over several tile shapes and limits",
             beats_in, beats_out);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
